>>> hdl/bbb_pkg.sv
// Shared types and constants of the two-region byte buffer.
package bbb_pkg;

  // Request codes carried on req_type_i.
  typedef enum logic [1:0] {
    REQ_WRITE  = 2'd0,
    REQ_READ   = 2'd1,
    REQ_PEEK   = 2'd2,
    REQ_REMOVE = 2'd3
  } req_e;

  // Status codes carried on status_o.
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NO_DATA   = 2'd1;
  localparam logic [1:0] ST_NO_SPACE  = 2'd2;
  localparam logic [1:0] ST_TOO_LONG  = 2'd3;

  // Write run targets.
  typedef enum logic [1:0] {
    RUN_NONE = 2'd0,
    RUN_A    = 2'd1,
    RUN_B    = 2'd2,
    RUN_REJ  = 2'd3
  } run_e;

  // Sequencer states, one-hot.
  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_READ   = 5'b00010,
    S_EMIT   = 5'b00100,
    S_CFETCH = 5'b01000,
    S_CMOVE  = 5'b10000
  } state_e;

endpackage

>>> hdl/bip_byte_buffer.sv
// Top level of the two-region byte buffer with its store and sequencer.
//
// A write byte is taken on each accepted start. A read or peek of N bytes
// runs a registered read of the store and a result beat in turn for each
// byte. A remove, error or empty answer comes straight from the idle state.
// When region A drains and region B holds bytes, B is copied down to the
// store start byte by byte, a fetch state then a move state for each byte,
// and busy_o stays high for that time. Results appear for exactly one cycle
// under result_valid_o and cannot be held off by the receiver.
module bip_byte_buffer #(
  parameter int CAPACITY = 4096,
  parameter int MAX_XFER = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  output logic       busy_o,
  input  logic [1:0] req_type_i,
  input  logic [6:0] length_i,
  input  logic [7:0] in_byte_i,
  input  logic       in_last_i,
  output logic       result_valid_o,
  output logic [7:0] out_byte_o,
  output logic       byte_valid_o,
  output logic       out_last_o,
  output logic [1:0] status_o
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = AW + 1;
  localparam logic [CW-1:0] CAP = CW'(CAPACITY);
  localparam logic [6:0] MAXX = 7'(MAX_XFER);

  logic [7:0] mem_q [CAPACITY];
  logic [7:0] rd_q;

  bbb_pkg::state_e state_q;
  logic [CW-1:0] a_begin_q, a_count_q, b_begin_q, b_count_q;
  logic          b_open_q;
  bbb_pkg::run_e run_q;
  logic [6:0]    off_q;
  logic [6:0]    len_q, idx_q;
  logic          is_read_q;
  logic [CW-1:0] cp_q;

  logic          accept;
  assign accept = start_i && !busy_o;
  assign busy_o = (state_q != bbb_pkg::S_IDLE);

  // Free space figures.
  logic [CW:0]   a_end, b_end;
  logic [CW-1:0] free_a, free_b;
  always_comb begin
    a_end  = {1'b0, a_begin_q} + {1'b0, a_count_q};
    b_end  = {1'b0, b_begin_q} + {1'b0, b_count_q};
    free_a = (a_end < {1'b0, CAP}) ? CW'({1'b0, CAP} - a_end) : '0;
    free_b = ({1'b0, a_begin_q} > b_end) ? CW'({1'b0, a_begin_q} - b_end) : '0;
  end

  // Write path decision for the current beat.
  logic          w_bopen;
  bbb_pkg::run_e w_run;
  logic [6:0]    w_off;
  logic          w_store;
  logic [CW-1:0] w_room;
  logic [CW:0]   w_pos;
  always_comb begin
    w_bopen = b_open_q;
    w_run   = run_q;
    w_off   = off_q;
    w_room  = '0;
    if (run_q == bbb_pkg::RUN_NONE) begin
      if (length_i > MAXX) begin
        w_run = bbb_pkg::RUN_REJ;
        w_off = 7'(bbb_pkg::ST_TOO_LONG);
      end else begin
        if (!b_open_q && (free_a < a_begin_q)) w_bopen = 1'b1;
        w_room = w_bopen ? (b_open_q ? free_b :
                 ((a_begin_q > '0) ? a_begin_q : '0)) : free_a;
        if (w_room < CW'(length_i)) begin
          w_run = bbb_pkg::RUN_REJ;
          w_off = 7'(bbb_pkg::ST_NO_SPACE);
        end else begin
          w_run = w_bopen ? bbb_pkg::RUN_B : bbb_pkg::RUN_A;
          w_off = '0;
        end
      end
    end
    // Room with B freshly opened is the whole gap before A.
    if (w_run == bbb_pkg::RUN_B)
      w_room = (w_bopen && !b_open_q) ? a_begin_q : free_b;
    else
      w_room = free_a;
    w_store = ((w_run == bbb_pkg::RUN_A) || (w_run == bbb_pkg::RUN_B)) &&
              (w_off < length_i) && (CW'(w_off) < w_room) && (w_off < MAXX);
    w_pos = (w_run == bbb_pkg::RUN_B)
          ? (((w_bopen && !b_open_q) ? {(CW+1){1'b0}} : b_end) + (CW+1)'(w_off))
          : a_end + (CW+1)'(w_off);
  end

  // Read address for the byte stream and compaction.
  logic [CW:0] r_pos;
  always_comb begin
    if (CW'(idx_q) < a_count_q) r_pos = {1'b0, a_begin_q} + (CW+1)'(idx_q);
    else r_pos = {1'b0, b_begin_q} + (CW+1)'(CW'(idx_q) - a_count_q);
    if (state_q == bbb_pkg::S_CFETCH) r_pos = {1'b0, b_begin_q} + {1'b0, cp_q};
  end

  // Store with one write port and one registered read port.
  logic          mem_we;
  logic [AW-1:0] mem_wa;
  logic [7:0]    mem_wd;
  always_comb begin
    mem_we = 1'b0;
    mem_wa = '0;
    mem_wd = in_byte_i;
    if (accept && req_type_i == bbb_pkg::REQ_WRITE && w_store && w_pos < {1'b0, CAP}) begin
      mem_we = 1'b1;
      mem_wa = w_pos[AW-1:0];
    end else if (state_q == bbb_pkg::S_CMOVE) begin
      mem_we = 1'b1;
      mem_wa = cp_q[AW-1:0];
      mem_wd = rd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_wa] <= mem_wd;
    rd_q <= (r_pos < {1'b0, CAP}) ? mem_q[r_pos[AW-1:0]] : 8'h00;
  end

  // Consumption result for read/remove.
  logic [CW-1:0] cons_len, na, nb, na_begin, na_count, nb_begin, nb_count;
  logic          need_fold, fold_copy;
  always_comb begin
    cons_len = CW'(accept ? length_i : len_q);
    na       = (cons_len < a_count_q) ? cons_len : a_count_q;
    nb       = ((cons_len - na) < b_count_q) ? (cons_len - na) : b_count_q;
    na_begin = a_begin_q + na;
    na_count = a_count_q - na;
    nb_begin = b_begin_q + nb;
    nb_count = b_count_q - nb;
    need_fold = (na_count == '0);
    fold_copy = b_open_q && (nb_count != '0) &&
                (({1'b0, nb_begin} + {1'b0, nb_count}) <= {1'b0, CAP});
  end

  // Sequencer and region bookkeeping.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bbb_pkg::S_IDLE;
      a_begin_q <= '0; a_count_q <= '0;
      b_begin_q <= '0; b_count_q <= '0;
      b_open_q <= 1'b0;
      run_q <= bbb_pkg::RUN_NONE;
      off_q <= '0; len_q <= '0; idx_q <= '0; is_read_q <= 1'b0; cp_q <= '0;
      result_valid_o <= 1'b0;
      out_byte_o <= '0; byte_valid_o <= 1'b0; out_last_o <= 1'b0;
      status_o <= bbb_pkg::ST_OK;
    end else begin
      result_valid_o <= 1'b0;
      case (state_q)
        bbb_pkg::S_IDLE: begin
          if (accept) begin
            if (req_type_i == bbb_pkg::REQ_WRITE) begin
              if (w_bopen && !b_open_q) begin
                b_open_q <= 1'b1; b_begin_q <= '0; b_count_q <= '0;
              end
              run_q <= w_run;
              off_q <= w_store ? w_off + 7'd1 : w_off;
              if (in_last_i) begin
                run_q <= bbb_pkg::RUN_NONE;
                off_q <= '0;
                result_valid_o <= 1'b1;
                out_byte_o <= '0; byte_valid_o <= 1'b0; out_last_o <= 1'b1;
                status_o <= bbb_pkg::ST_OK;
                if (w_run == bbb_pkg::RUN_REJ) status_o <= w_off[1:0];
                else if (w_run == bbb_pkg::RUN_B)
                  b_count_q <= ((w_bopen && !b_open_q) ? '0 : b_count_q) +
                               CW'(w_store ? w_off + 7'd1 : w_off);
                else a_count_q <= a_count_q + CW'(w_store ? w_off + 7'd1 : w_off);
              end
            end else begin
              run_q <= bbb_pkg::RUN_NONE;
              off_q <= '0;
              result_valid_o <= 1'b1;
              out_byte_o <= '0; byte_valid_o <= 1'b0; out_last_o <= 1'b1;
              status_o <= bbb_pkg::ST_OK;
              len_q <= length_i;
              is_read_q <= (req_type_i == bbb_pkg::REQ_READ);
              if (length_i > MAXX) begin
                status_o <= bbb_pkg::ST_TOO_LONG;
              end else if (req_type_i == bbb_pkg::REQ_REMOVE ||
                           (req_type_i == bbb_pkg::REQ_READ && length_i == '0)) begin
                if (req_type_i == bbb_pkg::REQ_READ && length_i == '0 &&
                    a_count_q != '0) begin
                  // nothing to settle
                end else if (need_fold) begin
                  a_begin_q <= '0; b_begin_q <= '0; b_count_q <= '0;
                  b_open_q <= 1'b0;
                  a_count_q <= '0;
                  if (fold_copy) begin
                    b_begin_q <= nb_begin; b_count_q <= nb_count;
                    cp_q <= '0;
                    if (nb_begin == '0) begin
                      a_count_q <= nb_count; b_begin_q <= '0; b_count_q <= '0;
                    end else state_q <= bbb_pkg::S_CFETCH;
                  end
                end else begin
                  a_begin_q <= na_begin; a_count_q <= na_count;
                  b_begin_q <= nb_begin; b_count_q <= nb_count;
                end
              end else if ((a_count_q + b_count_q) < CW'(length_i)) begin
                status_o <= bbb_pkg::ST_NO_DATA;
              end else if (length_i != '0) begin
                result_valid_o <= 1'b0;
                idx_q <= '0;
                state_q <= bbb_pkg::S_READ;
              end
            end
          end
        end
        bbb_pkg::S_READ: state_q <= bbb_pkg::S_EMIT;
        bbb_pkg::S_EMIT: begin
          result_valid_o <= 1'b1;
          out_byte_o <= rd_q; byte_valid_o <= 1'b1;
          status_o <= bbb_pkg::ST_OK;
          out_last_o <= (idx_q + 7'd1 == len_q);
          idx_q <= idx_q + 7'd1;
          state_q <= bbb_pkg::S_READ;
          if (idx_q + 7'd1 == len_q) begin
            state_q <= bbb_pkg::S_IDLE;
            if (is_read_q) begin
              if (need_fold) begin
                a_begin_q <= '0; b_begin_q <= '0; b_count_q <= '0;
                b_open_q <= 1'b0; a_count_q <= '0;
                if (fold_copy) begin
                  b_begin_q <= nb_begin; b_count_q <= nb_count; cp_q <= '0;
                  if (nb_begin == '0) begin
                    a_count_q <= nb_count; b_begin_q <= '0; b_count_q <= '0;
                  end else state_q <= bbb_pkg::S_CFETCH;
                end
              end else begin
                a_begin_q <= na_begin; a_count_q <= na_count;
                b_begin_q <= nb_begin; b_count_q <= nb_count;
              end
            end
          end
        end
        bbb_pkg::S_CFETCH: state_q <= bbb_pkg::S_CMOVE;
        bbb_pkg::S_CMOVE: begin
          cp_q <= cp_q + 1'b1;
          state_q <= bbb_pkg::S_CFETCH;
          if (cp_q + 1'b1 == b_count_q) begin
            a_count_q <= b_count_q;
            b_begin_q <= '0; b_count_q <= '0;
            state_q <= bbb_pkg::S_IDLE;
          end
        end
        default: state_q <= bbb_pkg::S_IDLE;
      endcase
    end
  end

  // Checks on the sequencer and region bookkeeping.
  assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot(state_q))
    else $error("state not one-hot");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == bbb_pkg::S_EMIT) |=> result_valid_o && byte_valid_o)
    else $error("missing data beat");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, a_begin_q} + {1'b0, a_count_q}) <= {1'b0, CAP})
    else $error("region A overruns the store");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == bbb_pkg::S_CMOVE) |-> b_open_q == 1'b0)
    else $error("B open during compaction");

endmodule
